// ===== rtl/cvbp_pkg.sv =====
package cvbp_pkg;

  localparam int CFG_DW = 18;
  localparam int CFG_AW = 3;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 26;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [CFG_AW-1:0] REG_GAIN        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FREQ_OFFSET = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PITCH_CTL   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RESO_OFFSET = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SAMPLE_RATE = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FREQ_CV_ON  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RESO_CV_ON  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_NONE        = 3'd7;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MBASE, ST_BASE, ST_MPITCH, ST_FPITCH, ST_DGO, ST_DWAIT,
    ST_TURN, ST_TWAIT, ST_CORDIC, ST_ROT, ST_ALPHA, ST_AWAIT,
    ST_MGA, ST_MGH, ST_MGL, ST_MC, ST_MA, ST_MEND, ST_YGO, ST_YWAIT, ST_EMIT
  } state_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cvbp_in_if.sv =====
interface cvbp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_in;
  logic signed [15:0] freq_cv;
  logic signed [15:0] reso_cv;

  modport source (output valid, output sample_in, output freq_cv, output reso_cv,
                  input ready);
  modport sink (input valid, input sample_in, input freq_cv, input reso_cv,
                output ready);
endinterface

// ===== rtl/cvbp_out_if.sv =====
interface cvbp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== rtl/cvbp_div.sv =====
module cvbp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cvbp_pkg::DIV_NW-1:0]    num,
  input  logic [cvbp_pkg::DIV_DW-1:0]    den,
  output logic                           done,
  output logic [cvbp_pkg::DIV_NW-1:0]    quot
);

  localparam logic [6:0] LAST = 7'(cvbp_pkg::DIV_NW - 1);

  logic                        busy;
  logic [6:0]                  cnt;
  logic [cvbp_pkg::DIV_DW-1:0] rem;
  logic [cvbp_pkg::DIV_DW-1:0] dv;
  logic [cvbp_pkg::DIV_NW-1:0] q;
  logic [cvbp_pkg::DIV_DW:0]   trial;
  logic [cvbp_pkg::DIV_DW:0]   diff;
  logic                        ge;

  assign trial = {rem, q[cvbp_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, dv};
  assign diff  = trial - {1'b0, dv};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      dv  <= den;
    end else if (busy) begin
      rem <= ge ? diff[cvbp_pkg::DIV_DW-1:0] : trial[cvbp_pkg::DIV_DW-1:0];
      q   <= {q[cvbp_pkg::DIV_NW-2:0], ge};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a run");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && dv != '0) |-> rem < dv)
    else $error("partial remainder out of range");

endmodule

// ===== rtl/cv_modulated_bandpass_biquad_top.sv =====
// Modulated band-pass biquad, one sample per request.
// din: request carries sample_in (Q1.23), freq_cv (Q1.15), reso_cv (Q4.12).
// dout: request carries sample_out (Q1.23, saturated), one per input.
// Config: wr_en/wr_index/wr_data write one register per cycle; index 0 gain,
// 1 freq_offset, 2 pitch_ctl, 3 reso_offset, 4 sample_rate, 5 freq_cv_on,
// 6 reso_cv_on; other indexes are dropped. Write only while idle.
// After a request is accepted, the sequencer makes four runs of the shared 64-step
// divider (pitch, angle, alpha, output), with the CORDIC (one step per cycle,
// TRIG_STAGES steps, at most 32) and the control and multiply states around them.
// A positive pitch swaps the pitch division for a multiply; a non-positive base
// skips it.
// din.ready is high only while the sequencer is idle, so a new sample is taken only
// once the last result is in the output register. A new request is taken while
// that result waits, and the next result holds until dout.ready.
// Reset (rst, synchronous) restores register defaults and clears the four
// history words and the output valid.
module cv_modulated_bandpass_biquad_top #(
  parameter int LOW_FREQ_LIMIT  = 20,
  parameter int HIGH_FREQ_LIMIT = 20000,
  parameter int RESO_LOW_LIMIT  = 410,
  parameter int RESO_HIGH_LIMIT = 65535,
  parameter int RESO_SCALE      = 32,
  parameter int TRIG_STAGES     = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  cvbp_in_if.sink                       din,
  cvbp_out_if.source                    dout,
  input  logic                          wr_en,
  input  logic [cvbp_pkg::CFG_AW-1:0]   wr_index,
  input  logic [cvbp_pkg::CFG_DW-1:0]   wr_data
);

  localparam int          NSTG     = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;
  localparam logic [5:0]  LAST_STG = 6'(NSTG - 1);
  localparam logic [29:0] FMIN     = 30'(LOW_FREQ_LIMIT * 32768);
  localparam logic [29:0] FMAX     = 30'(HIGH_FREQ_LIMIT * 32768);

  cvbp_pkg::state_t state, state_next;

  logic [15:0]        gain;
  logic [14:0]        freq_offset;
  logic signed [15:0] pitch_ctl;
  logic [15:0]        reso_offset;
  logic [17:0]        sample_rate;
  logic               freq_cv_on;
  logic               reso_cv_on;

  logic signed [23:0] x_in;
  logic signed [15:0] fcv;
  logic signed [15:0] rcv;
  logic [31:0]        base;
  logic [15:0]        q12;
  logic [29:0]        f15;
  logic [1:0]         quad;
  logic signed [32:0] cx, cy, cc, ss;
  logic signed [33:0] cz;
  logic [5:0]         stg;
  logic signed [31:0] alpha;
  logic [15:0]        ga_lo;
  logic signed [63:0] acc;
  logic signed [23:0] yq;
  logic signed [23:0] in_hist1, in_hist2, out_hist1, out_hist2;
  logic signed [23:0] oreg;
  logic               ov;

  logic signed [cvbp_pkg::MUL_AW-1:0] mul_a;
  logic signed [cvbp_pkg::MUL_BW-1:0] mul_b;
  logic signed [cvbp_pkg::MUL_PW-1:0] prod;

  logic                        div_start;
  logic [cvbp_pkg::DIV_NW-1:0] div_num;
  logic [cvbp_pkg::DIV_DW-1:0] div_den;
  logic                        div_done;
  logic [cvbp_pkg::DIV_NW-1:0] div_quot;

  logic               accept;
  logic               fcv_pos;
  logic signed [34:0] off_s;
  logic signed [34:0] base_w;
  logic               base_pos;
  logic signed [17:0] qs;
  logic [15:0]        q_clamped;
  logic signed [16:0] pdiv;
  logic signed [32:0] dx, dy;
  logic signed [33:0] at;
  logic signed [36:0] ga_w;
  logic signed [33:0] diff;
  logic signed [32:0] sabs;
  logic signed [33:0] a0s;
  logic [31:0]        a0;
  logic [63:0]        acc_abs;
  logic [31:0]        alpha_sat;
  logic [23:0]        y_sat;
  logic [29:0]        f_from_prod, f_from_div;

  cvbp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  function automatic logic [29:0] fclamp(input logic [63:0] v);
    logic [29:0] r;
    if (v < 64'(FMIN)) r = FMIN;
    else if (v > 64'(FMAX)) r = FMAX;
    else r = v[29:0];
    return r;
  endfunction

  assign accept = din.valid && din.ready;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= 16'd4096;
      freq_offset <= 15'd1000;
      pitch_ctl   <= '0;
      reso_offset <= 16'd4096;
      sample_rate <= 18'd48000;
      freq_cv_on  <= 1'b0;
      reso_cv_on  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        cvbp_pkg::REG_GAIN:        gain        <= wr_data[15:0];
        cvbp_pkg::REG_FREQ_OFFSET: freq_offset <= wr_data[14:0];
        cvbp_pkg::REG_PITCH_CTL:   pitch_ctl   <= $signed(wr_data[15:0]);
        cvbp_pkg::REG_RESO_OFFSET: reso_offset <= wr_data[15:0];
        cvbp_pkg::REG_SAMPLE_RATE: sample_rate <= wr_data[17:0];
        cvbp_pkg::REG_FREQ_CV_ON:  freq_cv_on  <= wr_data[0];
        cvbp_pkg::REG_RESO_CV_ON:  reso_cv_on  <= wr_data[0];
        default: ;
      endcase
    end
  end

  // combinational datapath helpers
  always_comb begin
    fcv_pos  = freq_cv_on && (fcv > 16'sd0);
    off_s    = $signed({20'd0, freq_offset});
    base_w   = fcv_pos ? ($signed(prod[34:0]) + ((off_s - 35'(LOW_FREQ_LIMIT)) <<< 15))
                       : (off_s <<< 15);
    base_pos = base_w > 35'sd0;
    qs       = $signed({2'b00, reso_offset}) + (reso_cv_on ? 18'(rcv) : 18'sd0);
    if (qs < 18'(RESO_LOW_LIMIT)) q_clamped = 16'(RESO_LOW_LIMIT);
    else if (qs > 18'(RESO_HIGH_LIMIT)) q_clamped = 16'(RESO_HIGH_LIMIT);
    else q_clamped = qs[15:0];
    pdiv     = 17'sd8192 - 17'(pitch_ctl);
    dx       = cy >>> stg[4:0];
    dy       = cx >>> stg[4:0];
    at       = $signed({2'b00, cvbp_pkg::atan_turn(stg[4:0])});
    ga_w     = prod[48:12];
    diff     = 34'(x_in) - 34'(in_hist2);
    sabs     = ss[32] ? -ss : ss;
    a0s      = 34'sd1073741824 + 34'(alpha);
    a0       = (a0s < 34'sd1) ? 32'd1 : a0s[31:0];
    acc_abs  = acc[63] ? 64'(-acc) : 64'(acc);
    f_from_prod = fclamp({13'd0, prod[59:13]} & 64'h0000_7FFF_FFFF_FFFF);
    f_from_div  = fclamp(div_quot);
    if (!ss[32]) alpha_sat = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
    else alpha_sat = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quot);
    if (!acc[63]) y_sat = (div_quot > 64'd8388607) ? 24'h7FFFFF : div_quot[23:0];
    else y_sat = (div_quot > 64'd8388608) ? 24'h800000 : 24'(-div_quot);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cvbp_pkg::ST_IDLE:   if (accept) state_next = cvbp_pkg::ST_MBASE;
      cvbp_pkg::ST_MBASE:  state_next = cvbp_pkg::ST_BASE;
      cvbp_pkg::ST_BASE: begin
        if (!base_pos) state_next = cvbp_pkg::ST_TURN;
        else if (pitch_ctl > 16'sd0) state_next = cvbp_pkg::ST_MPITCH;
        else state_next = cvbp_pkg::ST_DGO;
      end
      cvbp_pkg::ST_MPITCH: state_next = cvbp_pkg::ST_FPITCH;
      cvbp_pkg::ST_FPITCH: state_next = cvbp_pkg::ST_TURN;
      cvbp_pkg::ST_DGO:    state_next = cvbp_pkg::ST_DWAIT;
      cvbp_pkg::ST_DWAIT:  if (div_done) state_next = cvbp_pkg::ST_TURN;
      cvbp_pkg::ST_TURN:   state_next = cvbp_pkg::ST_TWAIT;
      cvbp_pkg::ST_TWAIT:  if (div_done) state_next = cvbp_pkg::ST_CORDIC;
      cvbp_pkg::ST_CORDIC: if (stg == LAST_STG) state_next = cvbp_pkg::ST_ROT;
      cvbp_pkg::ST_ROT:    state_next = cvbp_pkg::ST_ALPHA;
      cvbp_pkg::ST_ALPHA:  state_next = cvbp_pkg::ST_AWAIT;
      cvbp_pkg::ST_AWAIT:  if (div_done) state_next = cvbp_pkg::ST_MGA;
      cvbp_pkg::ST_MGA:    state_next = cvbp_pkg::ST_MGH;
      cvbp_pkg::ST_MGH:    state_next = cvbp_pkg::ST_MGL;
      cvbp_pkg::ST_MGL:    state_next = cvbp_pkg::ST_MC;
      cvbp_pkg::ST_MC:     state_next = cvbp_pkg::ST_MA;
      cvbp_pkg::ST_MA:     state_next = cvbp_pkg::ST_MEND;
      cvbp_pkg::ST_MEND:   state_next = cvbp_pkg::ST_YGO;
      cvbp_pkg::ST_YGO:    state_next = cvbp_pkg::ST_YWAIT;
      cvbp_pkg::ST_YWAIT:  if (div_done) state_next = cvbp_pkg::ST_EMIT;
      cvbp_pkg::ST_EMIT:   if (!ov || dout.ready) state_next = cvbp_pkg::ST_IDLE;
      default:             state_next = cvbp_pkg::ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    din.ready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      cvbp_pkg::ST_IDLE:   din.ready = 1'b1;
      cvbp_pkg::ST_MBASE: begin
        mul_a = 34'(fcv);
        mul_b = 26'(HIGH_FREQ_LIMIT);
      end
      cvbp_pkg::ST_MPITCH: begin
        mul_a = $signed({2'b00, base});
        mul_b = 26'sd8192 + 26'(pitch_ctl);
      end
      cvbp_pkg::ST_DGO: begin
        div_start = 1'b1;
        div_num   = {19'd0, base, 13'd0};
        div_den   = 32'($unsigned(pdiv));
      end
      cvbp_pkg::ST_TURN: begin
        div_start = 1'b1;
        div_num   = {17'd0, f15, 17'd0};
        div_den   = (sample_rate == '0) ? 32'd1 : {14'd0, sample_rate};
      end
      cvbp_pkg::ST_ALPHA: begin
        div_start = 1'b1;
        div_num   = {19'd0, sabs, 12'd0};
        div_den   = 32'({16'd0, q12} * 32'(RESO_SCALE));
      end
      cvbp_pkg::ST_MGA: begin
        mul_a = 34'(alpha);
        mul_b = $signed({10'd0, gain});
      end
      cvbp_pkg::ST_MGH: begin
        mul_a = diff;
        mul_b = 26'($signed(ga_w[36:16]));
      end
      cvbp_pkg::ST_MGL: begin
        mul_a = diff;
        mul_b = $signed({10'd0, ga_lo});
      end
      cvbp_pkg::ST_MC: begin
        mul_a = 34'(cc);
        mul_b = 26'(out_hist1);
      end
      cvbp_pkg::ST_MA: begin
        mul_a = 34'sd1073741824 - 34'(alpha);
        mul_b = 26'(out_hist2);
      end
      cvbp_pkg::ST_YGO: begin
        div_start = 1'b1;
        div_num   = acc_abs;
        div_den   = a0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cvbp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    prod <= cvbp_pkg::MUL_PW'(mul_a * mul_b);
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      cvbp_pkg::ST_IDLE: begin
        if (accept) begin
          x_in <= din.sample_in;
          fcv  <= din.freq_cv;
          rcv  <= din.reso_cv;
        end
      end
      cvbp_pkg::ST_BASE: begin
        base <= base_w[31:0];
        q12  <= q_clamped;
        if (!base_pos) f15 <= FMIN;
      end
      cvbp_pkg::ST_FPITCH: f15 <= f_from_prod;
      cvbp_pkg::ST_DWAIT:  if (div_done) f15 <= f_from_div;
      cvbp_pkg::ST_TWAIT: begin
        if (div_done) begin
          cx   <= cvbp_pkg::CORDIC_X0;
          cy   <= '0;
          cz   <= $signed({4'd0, div_quot[29:0]});
          quad <= div_quot[31:30];
          stg  <= '0;
        end
      end
      cvbp_pkg::ST_CORDIC: begin
        if (!cz[33]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at;
        end
        stg <= stg + 6'd1;
      end
      cvbp_pkg::ST_ROT: begin
        case (quad)
          2'd0: begin cc <= cx;  ss <= cy;  end
          2'd1: begin cc <= -cy; ss <= cx;  end
          2'd2: begin cc <= -cx; ss <= -cy; end
          default: begin cc <= cy; ss <= -cx; end
        endcase
      end
      cvbp_pkg::ST_AWAIT: if (div_done) alpha <= $signed(alpha_sat);
      cvbp_pkg::ST_MGH:   ga_lo <= ga_w[15:0];
      cvbp_pkg::ST_MGL:   acc <= 64'(prod) <<< 16;
      cvbp_pkg::ST_MC:    acc <= acc + 64'(prod);
      cvbp_pkg::ST_MA:    acc <= acc + (64'(prod) <<< 1);
      cvbp_pkg::ST_MEND:  acc <= acc - 64'(prod);
      cvbp_pkg::ST_YWAIT: if (div_done) yq <= $signed(y_sat);
      default: ;
    endcase
  end

  // output register and history
  always_ff @(posedge clk) begin
    if (rst) begin
      ov        <= 1'b0;
      in_hist1  <= '0;
      in_hist2  <= '0;
      out_hist1 <= '0;
      out_hist2 <= '0;
    end else begin
      if (ov && dout.ready) ov <= 1'b0;
      if (state == cvbp_pkg::ST_EMIT && (!ov || dout.ready)) begin
        ov        <= 1'b1;
        in_hist2  <= in_hist1;
        in_hist1  <= x_in;
        out_hist2 <= out_hist1;
        out_hist1 <= yq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cvbp_pkg::ST_EMIT && (!ov || dout.ready)) oreg <= yq;
  end

  assign dout.valid      = ov;
  assign dout.sample_out = oreg;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !din.ready)
    else $error("request taken while sample in progress");
  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    state == cvbp_pkg::ST_CORDIC |-> stg <= LAST_STG)
    else $error("CORDIC stage count overran");
  a_freq_range: assert property (@(posedge clk) disable iff (rst)
    state == cvbp_pkg::ST_TURN |-> (f15 >= FMIN && f15 <= FMAX))
    else $error("frequency outside clamp range");
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(state) == cvbp_pkg::ST_EMIT)
    else $error("output valid raised outside emit");

endmodule

// ===== sim/cvbp_filter_checker.sv =====
module cvbp_filter_checker (
  input  logic                        clk,
  input  logic                        rst,
  cvbp_in_if                          din,
  cvbp_out_if                         dout,
  input  logic                        wr_en,
  input  logic [cvbp_pkg::CFG_AW-1:0] wr_index,
  input  logic [cvbp_pkg::CFG_DW-1:0] wr_data,
  output int                          fails,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint F_LO = 20 * 32768;
  localparam longint F_HI = 20000 * 32768;
  localparam longint ONE_Q30 = 64'sd1073741824;

  longint atan_q32 [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  longint gain_q, foff, fpitch, qoff, srate;
  bit fcv_en, qcv_en;
  longint x1, x2, y1, y2;
  logic [23:0] expected_out [$];

  assign pending = expected_out.size();

  task automatic report(input string msg);
    $display("%0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void sincos(input logic [31:0] turn, output longint c,
                                 output longint s);
    longint x, y, z, dx, dy;
    x = cvbp_pkg::CORDIC_X0;
    y = 0;
    z = longint'(turn[29:0]);
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q32[i];
      end else begin
        x += dx; y -= dy; z += atan_q32[i];
      end
    end
    case (turn[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [23:0] filter_sample(input longint x0, input longint fcv,
                                                input longint rcv);
    longint base, f15, q12, c, s, alpha, ga, num, a0, y, fs;
    logic [63:0] turn64;
    if (fcv_en && fcv > 0) base = fcv * 20000 + (foff - 20) * 32768;
    else base = foff * 32768;
    if (base <= 0) f15 = F_LO;
    else if (fpitch > 0) f15 = (base * (8192 + fpitch)) >>> 13;
    else f15 = (base * 8192) / (8192 - fpitch);
    if (f15 < F_LO) f15 = F_LO;
    if (f15 > F_HI) f15 = F_HI;
    q12 = qoff + (qcv_en ? rcv : 0);
    if (q12 < 410) q12 = 410;
    if (q12 > 65535) q12 = 65535;
    fs = (srate != 0) ? srate : 1;
    turn64 = (64'(f15) << 17) / 64'(fs);
    sincos(turn64[31:0], c, s);
    alpha = (s * 4096) / (32 * q12);
    if (alpha > 64'sd2147483647) alpha = 64'sd2147483647;
    if (alpha < -64'sd2147483648) alpha = -64'sd2147483648;
    ga = (gain_q * alpha) >>> 12;
    num = ga * (x0 - x2) + 2 * c * y1 - (ONE_Q30 - alpha) * y2;
    a0 = ONE_Q30 + alpha;
    if (a0 < 1) a0 = 1;
    y = num / a0;
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    x2 = x1; x1 = x0; y2 = y1; y1 = y;
    return y[23:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_q = 4096; foff = 1000; fpitch = 0; qoff = 4096; srate = 48000;
      fcv_en = 0; qcv_en = 0; x1 = 0; x2 = 0; y1 = 0; y2 = 0;
      expected_out.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          cvbp_pkg::REG_GAIN:        gain_q = longint'(wr_data[15:0]);
          cvbp_pkg::REG_FREQ_OFFSET: foff = longint'(wr_data[14:0]);
          cvbp_pkg::REG_PITCH_CTL:   fpitch = longint'(signed'(wr_data[15:0]));
          cvbp_pkg::REG_RESO_OFFSET: qoff = longint'(wr_data[15:0]);
          cvbp_pkg::REG_SAMPLE_RATE: srate = longint'(wr_data[17:0]);
          cvbp_pkg::REG_FREQ_CV_ON:  fcv_en = wr_data[0];
          cvbp_pkg::REG_RESO_CV_ON:  qcv_en = wr_data[0];
          default: ;
        endcase
      end
      if (dout.valid && dout.ready) begin
        if (expected_out.size() == 0)
          report($sformatf("unexpected sample_out %h", dout.sample_out));
        else if (dout.sample_out !== expected_out[0])
          report($sformatf("sample_out %h, want %h", dout.sample_out, expected_out[0]));
        if (expected_out.size() != 0) void'(expected_out.pop_front());
      end
      if (din.valid && din.ready)
        expected_out.push_back(filter_sample(longint'(din.sample_in),
                                             longint'(din.freq_cv),
                                             longint'(din.reso_cv)));
    end
  end

endmodule

// ===== sim/cv_modulated_bandpass_biquad_top_test.sv =====
module cv_modulated_bandpass_biquad_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [cvbp_pkg::CFG_AW-1:0] wr_index = '0;
  logic [cvbp_pkg::CFG_DW-1:0] wr_data = '0;
  int fails, pending;
  int cyc = 0;
  int burst_left = 0;

  cvbp_in_if din ();
  cvbp_out_if dout ();

  cv_modulated_bandpass_biquad_top dut (
    .clk(clk), .rst(rst), .din(din), .dout(dout),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  cvbp_filter_checker chk (
    .clk(clk), .rst(rst), .din(din), .dout(dout), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data), .fails(fails), .pending(pending)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 4000000) begin
      $display("cv_modulated_bandpass_biquad_top: mismatch");
      $finish;
    end
  end

  // receiver stall pattern, with long hold-offs
  initial begin
    int mode, hold;
    mode = 0;
    hold = 0;
    dout.ready = 0;
    forever begin
      @(posedge clk);
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      if (cyc % 60000 == 30000) hold = 4000;
      if (hold > 0) begin
        hold--;
        dout.ready <= 0;
      end else begin
        case (mode)
          0: dout.ready <= 1;
          1: dout.ready <= ($urandom_range(0, 1) == 1);
          2: dout.ready <= ($urandom_range(0, 7) == 0);
          default: dout.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic set_reg(input logic [cvbp_pkg::CFG_AW-1:0] idx,
                         input logic [cvbp_pkg::CFG_DW-1:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    if (din.valid) din.valid <= 0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send(input logic [23:0] s, input logic [15:0] f, input logic [15:0] r);
    bit rdy;
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
      if (gap != 0) begin
        din.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    din.valid <= 1;
    din.sample_in <= s;
    din.freq_cv <= f;
    din.reso_cv <= r;
    do begin
      @(negedge clk);
      rdy = din.ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic random_config(input bit extreme);
    if (extreme) begin
      set_reg(cvbp_pkg::REG_GAIN, $urandom_range(0, 1) ? 18'h0ffff : 18'h30000);
      set_reg(cvbp_pkg::REG_FREQ_OFFSET, $urandom_range(0, 1) ? 18'd24000 : 18'd0);
      set_reg(cvbp_pkg::REG_PITCH_CTL, $urandom_range(0, 1) ? 18'h08000 : 18'h07fff);
      set_reg(cvbp_pkg::REG_RESO_OFFSET, $urandom_range(0, 1) ? 18'h0ffff : 18'h0);
      set_reg(cvbp_pkg::REG_SAMPLE_RATE, $urandom_range(0, 1) ? 18'd8000 : 18'd192000);
    end else begin
      set_reg(cvbp_pkg::REG_GAIN, 18'($urandom()));
      set_reg(cvbp_pkg::REG_FREQ_OFFSET, 18'($urandom_range(0, 24000)));
      set_reg(cvbp_pkg::REG_PITCH_CTL,
              18'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8191)));
      set_reg(cvbp_pkg::REG_RESO_OFFSET,
              18'($urandom_range(0, 1) ? $urandom() : $urandom_range(410, 20000)));
      set_reg(cvbp_pkg::REG_SAMPLE_RATE,
              $urandom_range(0, 15) == 0 ? 18'd0 : 18'($urandom_range(8000, 192000)));
    end
    set_reg(cvbp_pkg::REG_FREQ_CV_ON, 18'($urandom()));
    set_reg(cvbp_pkg::REG_RESO_CV_ON, 18'($urandom()));
    set_reg(cvbp_pkg::REG_NONE, 18'($urandom()));
    wr_en <= 0;
    @(posedge clk);
  endtask

  initial begin
    din.valid = 0;
    din.sample_in = '0;
    din.freq_cv = '0;
    din.reso_cv = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default setup, field extremes
    send(24'h7fffff, 16'h7fff, 16'h7fff);
    send(24'h800000, 16'h8000, 16'h8000);
    send(24'h000000, 16'h0000, 16'h0000);
    send(24'h7fffff, 16'h0001, 16'hffff);
    send(24'h800000, 16'hffff, 16'h0001);
    drain();
    // control inputs on, high gain, low Q, zero rate
    set_reg(cvbp_pkg::REG_FREQ_CV_ON, 18'h1);
    set_reg(cvbp_pkg::REG_RESO_CV_ON, 18'h1);
    set_reg(cvbp_pkg::REG_GAIN, 18'h3ffff);
    set_reg(cvbp_pkg::REG_RESO_OFFSET, 18'd0);
    set_reg(cvbp_pkg::REG_SAMPLE_RATE, 18'd0);
    set_reg(cvbp_pkg::REG_PITCH_CTL, 18'h08000);
    wr_en <= 0;
    @(posedge clk);
    send(24'h7fffff, 16'h7fff, 16'h8000);
    send(24'h800000, 16'h8000, 16'h7fff);
    send(24'h7fffff, 16'h0001, 16'h0000);
    send(24'h800000, 16'h7fff, 16'h7fff);
    drain();
    set_reg(cvbp_pkg::REG_FREQ_OFFSET, 18'd0);
    set_reg(cvbp_pkg::REG_PITCH_CTL, 18'h07fff);
    set_reg(cvbp_pkg::REG_SAMPLE_RATE, 18'd8000);
    set_reg(cvbp_pkg::REG_RESO_OFFSET, 18'hffff);
    wr_en <= 0;
    @(posedge clk);
    send(24'h7fffff, 16'h0000, 16'h7fff);
    send(24'h800000, 16'h8000, 16'h8000);
    send(24'h7fffff, 16'h7fff, 16'h0000);
    send(24'h123456, 16'h0001, 16'h0001);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      random_config(ph % 4 == 1);
      for (int n = 0; n < 104; n++) begin
        if ($urandom_range(0, 4) == 0)
          send(24'($urandom()), 16'($urandom()), 16'($urandom()));
        else
          send($urandom_range(0, 1) ? 24'(signed'($urandom_range(0, 8000)) - 4000)
                                    : 24'($urandom()),
               $urandom_range(0, 3) ? 16'($urandom_range(0, 32767)) : 16'($urandom()),
               16'($urandom_range(0, 4096)) - 16'd2048);
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("cv_modulated_bandpass_biquad_top: match");
    else
      $display("cv_modulated_bandpass_biquad_top: mismatch");
    $finish;
  end
endmodule
